@@ hw/rtl/dats_pkg.sv @@
// Package for the drone arm / takeoff / land sequencer.
// Holds the flight state, event and register index codes and reset constants.
// No dependencies.
package dats_pkg;

   // Flight states, in order of progress
   typedef enum logic [2:0] {
      ST_INIT    = 3'd0,
      ST_STANDBY = 3'd1,
      ST_TAKEOFF = 3'd2,
      ST_FLYING  = 3'd3,
      ST_LANDING = 3'd4
   } flight_state_type;

   // Event kinds carried on req_tuser
   typedef enum logic [1:0] {
      REQ_SLOW_TICK = 2'd0,
      REQ_FAST_TICK = 2'd1,
      REQ_LAND      = 2'd2,
      REQ_ESTOP     = 2'd3
   } req_kind_type;

   // Configuration register indexes
   typedef enum logic [2:0] {
      CSR_STICK_LOW    = 3'd0,
      CSR_STICK_HIGH   = 3'd1,
      CSR_UNLOCK_HOLD  = 3'd2,
      CSR_LAND_HEIGHT  = 3'd3,
      CSR_LAND_HOLD    = 3'd4
   } csr_index_type;

   localparam int RampTicksDefault = 10;
   localparam int HoldTicksDefault = 20;

   localparam logic signed [15:0] StickLowReset   = -16'sd800;
   localparam logic signed [15:0] StickHighReset  = 16'sd800;
   localparam logic [7:0]         UnlockHoldReset = 8'd20;
   localparam logic [15:0]        LandHeightReset = 16'd200;
   localparam logic [4:0]         LandHoldReset   = 5'd20;

   localparam logic [10:0] ThrIdle = 11'd1000;
   localparam logic [10:0] ThrHold = 11'd1500;

   // Arm switch streak: stop at this count, saturate at the cap
   localparam logic [3:0] StreakTrip = 4'd3;
   localparam logic [3:0] StreakCap  = 4'd8;

   localparam int ReqDataWidth = 96;
   localparam int RspDataWidth = 48;

endpackage

@@ hw/rtl/drone_arm_takeoff_land_sequencer.sv @@
// An accepted req item goes to the input register, then to the result register.
// Throughput: one item per cycle while rsp is not stalled; the state update is a
// single pass of logic between the input register and the result register.
// A stalled rsp side holds the result register and the input register fills once.
// Reset (synchronous, active high) clears control state to init and loads the
// configuration registers with their default values.
//
// Single-pass flight sequencer; depends on dats_pkg.
module drone_arm_takeoff_land_sequencer #(
   parameter int RAMP_LEN = dats_pkg::RampTicksDefault,
   parameter int HOLD_LEN = dats_pkg::HoldTicksDefault
) (
   input  logic                              clock,
   input  logic                              reset,
   // req_tdata from bit 0: link_up, throttle_stick, roll_stick, pitch_stick,
   // yaw_stick, mode_switch_a, mode_switch_b, arm_switch, landing_button,
   // height_valid, height_mm, zero fill
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [dats_pkg::ReqDataWidth-1:0] req_tdata,
   input  logic [1:0]                        req_tuser,  // req_type
   // rsp_tdata from bit 0: flight_state, flight_mode, armed, motors_on,
   // throttle_update, throttle_pair_one, throttle_pair_two, emergency_stop,
   // beep_alarm, unlock_count, takeoff_count, zero fill
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [dats_pkg::RspDataWidth-1:0] rsp_tdata,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [2:0]                        csr_index,
   input  logic [15:0]                       csr_data
);

   localparam int TotalRaw = RAMP_LEN + HOLD_LEN;
   localparam logic [4:0] TakeoffTotal = (TotalRaw > 31) ? 5'd31 : 5'(TotalRaw);
   localparam logic [4:0] RampLast = 5'(RAMP_LEN);

   // Configuration registers
   logic signed [15:0] stick_low_ff, stick_high_ff;
   logic [7:0]         unlock_hold_ff;
   logic [15:0]        land_height_ff;
   logic [4:0]         land_hold_ff;

   // Input register
   logic                              in_valid_ff;
   logic [dats_pkg::ReqDataWidth-1:0] in_data_ff;
   logic [1:0]                        in_kind_ff;

   // Sequencer state
   dats_pkg::flight_state_type state_ff, state_in;
   logic [3:0] mode_ff, mode_in;
   logic [7:0] unlock_ff, unlock_in;
   logic [4:0] takeoff_ff, takeoff_in;
   logic [4:0] button_ff, button_in;
   logic [4:0] low_ff, low_in;
   logic [3:0] streak_ff, streak_in;
   logic       armed_ff, armed_in;
   logic       enable_ff, enable_in;

   // Result register
   logic                              out_valid_ff;
   logic [dats_pkg::RspDataWidth-1:0] out_data_ff, out_data_in;

   logic        advance;
   logic        upd, stop, beep, force_stop, pat;
   logic [10:0] thr_one, thr_two;

   // Unpacked input fields
   logic               f_link;
   logic signed [15:0] f_throttle, f_roll, f_pitch, f_yaw;
   logic [1:0]         f_sw_a, f_sw_b, f_arm, f_button;
   logic               f_hvalid;
   logic [15:0]        f_height;

   // Ramp throttle table, indexed by takeoff tick
   logic [10:0] ramp_lut [32];
   for (genvar g = 0; g < 32; g++) begin : g_ramp
      assign ramp_lut[g] = 11'(1000 + (500 * g) / RAMP_LEN);
   end

   assign f_link     = in_data_ff[0];
   assign f_throttle = in_data_ff[16:1];
   assign f_roll     = in_data_ff[32:17];
   assign f_pitch    = in_data_ff[48:33];
   assign f_yaw      = in_data_ff[64:49];
   assign f_sw_a     = in_data_ff[66:65];
   assign f_sw_b     = in_data_ff[68:67];
   assign f_arm      = in_data_ff[70:69];
   assign f_button   = in_data_ff[72:71];
   assign f_hvalid   = in_data_ff[73];
   assign f_height   = in_data_ff[89:74];

   // Move an item into the result register when it is free or being drained
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign csr_ready  = 1'b1;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         stick_low_ff   <= dats_pkg::StickLowReset;
         stick_high_ff  <= dats_pkg::StickHighReset;
         unlock_hold_ff <= dats_pkg::UnlockHoldReset;
         land_height_ff <= dats_pkg::LandHeightReset;
         land_hold_ff   <= dats_pkg::LandHoldReset;
      end else if (csr_valid) begin
         unique case (dats_pkg::csr_index_type'(csr_index))
            dats_pkg::CSR_STICK_LOW:   stick_low_ff   <= csr_data;
            dats_pkg::CSR_STICK_HIGH:  stick_high_ff  <= csr_data;
            dats_pkg::CSR_UNLOCK_HOLD: unlock_hold_ff <= csr_data[7:0];
            dats_pkg::CSR_LAND_HEIGHT: land_height_ff <= csr_data;
            dats_pkg::CSR_LAND_HOLD:   land_hold_ff   <= csr_data[4:0];
            default: ;
         endcase
      end
   end

   // Unlock stick pattern: throttle, roll, pitch low and yaw high
   assign pat = (f_throttle < stick_low_ff) && (f_roll < stick_low_ff) &&
                (f_pitch < stick_low_ff) && (f_yaw > stick_high_ff);

   // Next state and result for the item in the input register
   always_comb begin
      state_in   = state_ff;
      mode_in    = mode_ff;
      unlock_in  = unlock_ff;
      takeoff_in = takeoff_ff;
      button_in  = button_ff;
      low_in     = low_ff;
      streak_in  = streak_ff;
      armed_in   = armed_ff;
      enable_in  = enable_ff;
      upd        = 1'b0;
      thr_one    = dats_pkg::ThrIdle;
      thr_two    = dats_pkg::ThrIdle;
      beep       = 1'b0;
      force_stop = 1'b0;

      unique case (dats_pkg::req_kind_type'(in_kind_ff))
         dats_pkg::REQ_SLOW_TICK: begin
            if (!f_link) begin
               force_stop = 1'b1;
            end else begin
               if (f_arm == 2'd0) begin
                  if (streak_ff < dats_pkg::StreakCap) streak_in = streak_ff + 4'd1;
               end else begin
                  streak_in = 4'd0;
               end
               if (streak_in >= dats_pkg::StreakTrip) begin
                  beep       = (state_ff >= dats_pkg::ST_TAKEOFF);
                  force_stop = 1'b1;
               end else begin
                  unique case (state_ff)
                     dats_pkg::ST_INIT: begin
                        armed_in   = 1'b0;
                        unlock_in  = 8'd0;
                        takeoff_in = 5'd0;
                        enable_in  = 1'b0;
                        state_in   = dats_pkg::ST_STANDBY;
                     end
                     dats_pkg::ST_STANDBY: begin
                        if (pat) begin
                           if (unlock_ff != 8'hFF) unlock_in = unlock_ff + 8'd1;
                        end else begin
                           unlock_in = 8'd0;
                        end
                        if (unlock_in >= unlock_hold_ff) begin
                           enable_in  = 1'b0;
                           takeoff_in = 5'd0;
                           state_in   = dats_pkg::ST_TAKEOFF;
                        end
                     end
                     dats_pkg::ST_TAKEOFF: begin
                        enable_in = 1'b1;
                        if (takeoff_ff < TakeoffTotal) takeoff_in = takeoff_ff + 5'd1;
                        if (takeoff_in <= RampLast) begin
                           thr_one = ramp_lut[takeoff_in];
                        end else begin
                           thr_one = dats_pkg::ThrHold;
                           thr_two = dats_pkg::ThrHold;
                        end
                        upd = 1'b1;
                        if (takeoff_in >= TakeoffTotal) begin
                           armed_in = 1'b1;
                           state_in = dats_pkg::ST_FLYING;
                        end
                     end
                     dats_pkg::ST_FLYING: begin
                        mode_in = ({2'b00, f_sw_a} << 1) + {2'b00, f_sw_a} + {2'b00, f_sw_b};
                     end
                     dats_pkg::ST_LANDING: ;
                     default: force_stop = 1'b1;
                  endcase
               end
            end
         end
         dats_pkg::REQ_FAST_TICK: begin
            // Landing button hold while flying
            if (state_ff == dats_pkg::ST_FLYING && f_button == 2'd1) begin
               if (button_ff < land_hold_ff) button_in = button_ff + 5'd1;
               if (button_in >= land_hold_ff) begin
                  low_in   = 5'd0;
                  state_in = dats_pkg::ST_LANDING;
               end
            end else begin
               button_in = 5'd0;
            end
            // Touchdown confirmation, also on the tick that entered landing
            if (state_in == dats_pkg::ST_LANDING) begin
               if (f_hvalid && f_height < land_height_ff) begin
                  if (low_in < land_hold_ff) low_in = low_in + 5'd1;
                  if (low_in >= land_hold_ff) force_stop = 1'b1;
               end else begin
                  low_in = 5'd0;
               end
            end
         end
         dats_pkg::REQ_LAND: begin
            if (state_ff == dats_pkg::ST_FLYING) begin
               low_in   = 5'd0;
               state_in = dats_pkg::ST_LANDING;
            end
         end
         dats_pkg::REQ_ESTOP: force_stop = 1'b1;
      endcase

      // Forced stop: disarm, clear the takeoff, unlock, button and touchdown counts, fall back to standby
      if (force_stop) begin
         armed_in   = 1'b0;
         takeoff_in = 5'd0;
         unlock_in  = 8'd0;
         button_in  = 5'd0;
         low_in     = 5'd0;
         enable_in  = 1'b0;
         state_in   = dats_pkg::ST_STANDBY;
      end
      stop = force_stop;

      out_data_in = {1'b0, takeoff_in, unlock_in, beep, stop, thr_two, thr_one, upd,
                     enable_in, armed_in, mode_in, state_in};
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_data_ff <= req_tdata;
         in_kind_ff <= req_tuser;
      end
   end

   // State update, one item per advance
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= dats_pkg::ST_INIT;
         mode_ff    <= 4'd0;
         unlock_ff  <= 8'd0;
         takeoff_ff <= 5'd0;
         button_ff  <= 5'd0;
         low_ff     <= 5'd0;
         streak_ff  <= 4'd0;
         armed_ff   <= 1'b0;
         enable_ff  <= 1'b0;
      end else if (advance) begin
         state_ff   <= state_in;
         mode_ff    <= mode_in;
         unlock_ff  <= unlock_in;
         takeoff_ff <= takeoff_in;
         button_ff  <= button_in;
         low_ff     <= low_in;
         streak_ff  <= streak_in;
         armed_ff   <= armed_in;
         enable_ff  <= enable_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

`ifndef NO_ASSERTIONS
   // Armed only once takeoff completed
   a_armed_state: assert property (@(posedge clock) disable iff (reset)
      armed_ff |-> (state_ff == dats_pkg::ST_FLYING || state_ff == dats_pkg::ST_LANDING))
      else $error("armed outside flying or landing");

   // Takeoff count never passes the sequence length
   a_takeoff_bound: assert property (@(posedge clock) disable iff (reset)
      takeoff_ff <= TakeoffTotal)
      else $error("takeoff count beyond sequence length");

   // Arm switch streak saturates
   a_streak_bound: assert property (@(posedge clock) disable iff (reset)
      streak_ff <= dats_pkg::StreakCap)
      else $error("arm switch streak beyond cap");

   // A stop result always shows standby with motors off; a beep comes with a stop
   a_stop_result: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_data_ff[32]) |->
         (out_data_ff[2:0] == dats_pkg::ST_STANDBY && !out_data_ff[7] && !out_data_ff[8]))
      else $error("stop result not in disarmed standby");

   a_beep_stop: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_data_ff[33]) |-> out_data_ff[32])
      else $error("beep without stop");
`endif

endmodule
